/* rtl/pfa_pkg.sv */
package pfa_pkg;

    localparam int NUM_BLOCKS = 8;
    localparam int SIZE_BITS  = 16;
    localparam int BLK_W      = $clog2(NUM_BLOCKS);
    localparam int LEVELS     = $clog2(NUM_BLOCKS);
    localparam int LEAVES     = 1 << LEVELS;
    localparam int CNT_W      = 4;
    localparam int POL_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_WORST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 2'd1;

    localparam logic [CNT_W-1:0] BLOCKS_RESET = 4'd8;

    typedef struct packed {
        logic                 command;
        logic [BLK_W-1:0]     block_select;
        logic [SIZE_BITS-1:0] amount;
    } t_in_item;

    typedef struct packed {
        logic                 granted;
        logic [BLK_W-1:0]     chosen_block;
        logic [SIZE_BITS-1:0] remaining;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic search;
        logic commit;
    } t_ctrl_cmd;

endpackage

/* rtl/partition_fit_allocator.sv */
// Partition allocator with first, best and worst fit placement.
// The input word, the chosen partition and the result word are registered in turn.
// A new word is taken while idle or in the subtract and write-back step of the last one,
// once the output word is free, as the search over all partitions depends on that step.
// Reset (synchronous, active low) clears control state and sets first fit over eight
// partitions; partition free sizes are not cleared and must be loaded before use.
module partition_fit_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  pfa_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output pfa_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_we,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pfa_pkg::*;

    t_ctrl_cmd cmd;

    pfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    pfa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_out_data)
    );

endmodule

/* rtl/pfa_ctrl.sv */
module pfa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output pfa_pkg::t_ctrl_cmd o_cmd
);
    import pfa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_UPDATE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   in_accept;

    // The output word can be replaced when it is empty or being taken now.
    assign out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) || ((r_state == ST_UPDATE) && out_free));
    assign in_accept = i_in_valid && !o_in_stall;

    always_comb begin
        o_cmd.capture = in_accept;
        o_cmd.search  = (r_state == ST_SEARCH);
        o_cmd.commit  = (r_state == ST_UPDATE) && out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) begin
                    n_state = in_accept ? ST_SEARCH : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_search_then_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |=> (r_state == ST_UPDATE))
        else $error("search step not followed by update");

    a_accept_starts_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ST_SEARCH))
        else $error("accepted word did not start a search");

    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_out_valid)
        else $error("committed result not presented");

endmodule

/* rtl/pfa_dp.sv */
module pfa_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pfa_pkg::t_ctrl_cmd                  i_cmd,
    input  pfa_pkg::t_in_item                   i_in_data,
    input  logic                                i_cfg_we,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output pfa_pkg::t_out_item                  o_out_data
);
    import pfa_pkg::*;

    typedef struct packed {
        logic                 valid;
        logic [BLK_W-1:0]     idx;
        logic [SIZE_BITS-1:0] size;
    } t_cand;

    logic [POL_W-1:0]     r_fit_policy;
    logic [CNT_W-1:0]     r_blocks_in_use;
    logic [SIZE_BITS-1:0] r_free [NUM_BLOCKS];
    t_in_item             r_item;
    logic                 r_found;
    logic [BLK_W-1:0]     r_pick;
    t_out_item            r_out;

    t_cand                tree [LEVELS+1][LEAVES];
    logic [SIZE_BITS-1:0] diff;

    // Lower-index operand wins ties; policy code three acts as first fit.
    function automatic t_cand pick_pair(input t_cand a, input t_cand b,
                                        input logic [POL_W-1:0] pol);
        t_cand r;
        r = a;
        if (!a.valid) begin
            r = b;
        end else if (b.valid) begin
            if ((pol == POL_BEST) && (b.size < a.size)) begin
                r = b;
            end else if ((pol == POL_WORST) && (b.size > a.size)) begin
                r = b;
            end
        end
        return r;
    endfunction

    always_comb begin
        for (int l = 0; l <= LEVELS; l++) begin
            for (int k = 0; k < LEAVES; k++) begin
                tree[l][k] = '0;
            end
        end
        for (int j = 0; j < NUM_BLOCKS; j++) begin
            tree[0][j].idx   = BLK_W'(j);
            tree[0][j].size  = r_free[j];
            tree[0][j].valid = (r_free[j] >= r_item.amount) &&
                               (CNT_W'(j) < r_blocks_in_use);
        end
        for (int l = 0; l < LEVELS; l++) begin
            for (int k = 0; k < LEAVES / 2; k++) begin
                if (k < (LEAVES >> (l + 1))) begin
                    tree[l+1][k] = pick_pair(tree[l][2*k], tree[l][2*k+1], r_fit_policy);
                end
            end
        end
    end

    assign diff = r_free[r_pick] - r_item.amount;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_policy    <= POL_FIRST;
            r_blocks_in_use <= BLOCKS_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_FIT_POLICY) begin
                r_fit_policy <= i_cfg_data[POL_W-1:0];
            end else if (i_cfg_index == CFG_BLOCKS_IN_USE) begin
                r_blocks_in_use <= i_cfg_data[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.search) begin
            r_found <= tree[LEVELS][0].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.search) begin
            r_pick <= tree[LEVELS][0].idx;
        end
        if (i_cmd.commit) begin
            if (r_item.command == CMD_LOAD) begin
                r_free[r_item.block_select] <= r_item.amount;
                r_out                       <= '0;
            end else if (r_found) begin
                r_free[r_pick] <= diff;
                r_out          <= '{granted: 1'b1, chosen_block: r_pick, remaining: diff};
            end else begin
                r_out <= '0;
            end
        end
        // The update cycle reads the old word before a new one lands here.
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
    end

    assign o_out_data = r_out;

    a_grant_written_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (r_item.command == CMD_ALLOC) && r_found) |=>
        (r_out.granted && (r_free[r_out.chosen_block] == r_out.remaining)))
        else $error("granted remainder differs from stored free size");

endmodule

/* verif/pfa_checker.sv */
module pfa_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  pfa_pkg::t_in_item              i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  pfa_pkg::t_out_item             i_out_data,
    input  logic                           i_cfg_we,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_mismatches,
    output int                             o_pending
);
    import pfa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic [SIZE_BITS-1:0] part_free [NUM_BLOCKS];
    logic [POL_W-1:0]     cur_policy;
    logic [CNT_W-1:0]     cur_span;
    t_out_item            grants_due[$];
    int                   mismatches = 0;

    // Applies one input word to the partition table and returns the result word.
    function automatic t_out_item place_word(input t_in_item w);
        t_out_item r;
        int        span;
        int        pick;
        int        j;
        bit        hit;
        r    = '0;
        hit  = 1'b0;
        pick = 0;
        if (w.command == CMD_LOAD) begin
            part_free[w.block_select] = w.amount;
            return r;
        end
        span = (cur_span > NUM_BLOCKS) ? NUM_BLOCKS : int'(cur_span);
        for (j = 0; j < span; j++) begin
            if (part_free[j] >= w.amount) begin
                if (!hit) begin
                    hit  = 1'b1;
                    pick = j;
                end else if (cur_policy == POL_BEST && part_free[j] < part_free[pick]) begin
                    pick = j;
                end else if (cur_policy == POL_WORST && part_free[j] > part_free[pick]) begin
                    pick = j;
                end
            end
        end
        if (hit) begin
            part_free[pick] = part_free[pick] - w.amount;
            r.granted       = 1'b1;
            r.chosen_block  = pick[BLK_W-1:0];
            r.remaining     = part_free[pick];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, field, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            grants_due.delete();
            cur_policy = POL_FIRST;
            cur_span   = BLOCKS_RESET;
            for (int k = 0; k < NUM_BLOCKS; k++) begin
                part_free[k] = '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FIT_POLICY) begin
                    cur_policy = i_cfg_data[POL_W-1:0];
                end else if (i_cfg_index == CFG_BLOCKS_IN_USE) begin
                    cur_span = i_cfg_data[CNT_W-1:0];
                end
            end
            if (i_in_valid && !i_in_stall) begin
                grants_due.push_back(place_word(i_in_data));
            end
            if (i_out_valid && !i_out_stall) begin
                if (grants_due.size() == 0) begin
                    report_mismatch("unexpected word", int'(i_out_data), 0);
                end else begin
                    want = grants_due.pop_front();
                    if (i_out_data.granted !== want.granted) begin
                        report_mismatch("granted", int'(i_out_data.granted),
                                        int'(want.granted));
                    end
                    if (i_out_data.chosen_block !== want.chosen_block) begin
                        report_mismatch("chosen_block", int'(i_out_data.chosen_block),
                                        int'(want.chosen_block));
                    end
                    if (i_out_data.remaining !== want.remaining) begin
                        report_mismatch("remaining", int'(i_out_data.remaining),
                                        int'(want.remaining));
                    end
                end
            end
        end
        o_pending    <= grants_due.size();
        o_mismatches <= mismatches;
    end

endmodule

/* verif/tb_partition_fit_allocator.sv */
module tb_partition_fit_allocator;
    import pfa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                  i_clk     = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_data   = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_stall;
    logic                  out_valid;
    t_out_item             out_data;
    int                    mismatches;
    int                    pending_words;
    bit                    no_gaps = 1'b0;

    partition_fit_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    pfa_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending_words)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_word(input logic cmd, input logic [BLK_W-1:0] sel,
                             input logic [SIZE_BITS-1:0] amt);
        t_in_item w;
        int       gap;
        w.command      = cmd;
        w.block_select = sel;
        w.amount       = amt;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic load_part(input logic [BLK_W-1:0] sel, input logic [SIZE_BITS-1:0] amt);
        send_word(CMD_LOAD, sel, amt);
    endtask

    // The block select of a request is ignored, so it carries random bits.
    task automatic request(input logic [SIZE_BITS-1:0] amt);
        send_word(CMD_ALLOC, BLK_W'($urandom), amt);
    endtask

    // Stops offering words and lets every expected result come back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_policy_span(input logic [POL_W-1:0] policy, input logic [CNT_W-1:0] span,
                                   input bit junk_bits);
        logic [CFG_DATA_W-1:0] pol_word;
        pol_word = CFG_DATA_W'(policy);
        if (junk_bits) begin
            pol_word[CFG_DATA_W-1:POL_W] = (CFG_DATA_W-POL_W)'($urandom);
        end
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FIT_POLICY;
        cfg_data  <= pol_word;
        @(posedge i_clk);
        cfg_index <= CFG_BLOCKS_IN_USE;
        cfg_data  <= CFG_DATA_W'(span);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Result side: random stalls, quiet windows, and now and then a long hold-off
    // so that the block fills up and stalls its input.
    initial begin
        int hold;
        int taken;
        taken = 0;
        while (!rst_n) @(posedge i_clk);
        forever begin
            if (taken % 250 == 120) begin
                hold = 70;
            end else if ((taken / 40) % 4 == 3) begin
                hold = 0;
            end else begin
                hold = $urandom_range(0, 9);
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!out_valid);
            taken++;
        end
    end

    logic [POL_W-1:0] phase_policy [9] = '{POL_FIRST, POL_BEST, POL_WORST, 2'd3,
                                           POL_BEST, POL_WORST, POL_FIRST, POL_BEST,
                                           POL_WORST};
    logic [CNT_W-1:0] phase_span [9] = '{4'd8, 4'd8, 4'd8, 4'd8, 4'd1, 4'd15, 4'd0,
                                         4'd3, 4'd9};

    initial begin
        logic [POL_W-1:0]     policy;
        logic [CNT_W-1:0]     span;
        logic [SIZE_BITS-1:0] amt;
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Every partition is loaded before the first request reads the table.
        load_part(3'd0, 16'd0);
        load_part(3'd1, 16'hFFFF);
        load_part(3'd2, 16'd100);
        load_part(3'd3, 16'd300);
        load_part(3'd4, 16'd200);
        load_part(3'd5, 16'hFFFF);
        load_part(3'd6, 16'd50);
        load_part(3'd7, 16'd1);
        request(16'd0);
        request(16'hFFFF);
        request(16'd150);
        wait_idle();
        set_policy_span(POL_BEST, 4'd8, 1'b0);
        request(16'd150);
        request(16'd50);
        request(16'hFFFF);
        request(16'hFFFF);
        wait_idle();
        set_policy_span(POL_WORST, 4'd8, 1'b0);
        load_part(3'd2, 16'd500);
        load_part(3'd4, 16'd500);
        request(16'd10);
        wait_idle();
        set_policy_span(2'd3, 4'd8, 1'b0);
        request(16'd1);
        wait_idle();
        set_policy_span(POL_FIRST, 4'd0, 1'b0);
        request(16'd0);
        wait_idle();
        set_policy_span(POL_WORST, 4'd15, 1'b0);
        request(16'd1);
        wait_idle();
        set_policy_span(POL_BEST, 4'd1, 1'b0);
        request(16'd0);

        for (int phase = 0; phase < 10; phase++) begin
            wait_idle();
            if (phase < 9) begin
                policy = phase_policy[phase];
                span   = phase_span[phase];
            end else begin
                policy = POL_W'($urandom_range(0, 3));
                span   = CNT_W'($urandom_range(0, 15));
            end
            set_policy_span(policy, span, 1'b1);
            no_gaps = (phase % 4 == 2);
            for (int n = 0; n < 75; n++) begin
                if ($urandom_range(0, 99) < 25) begin
                    amt = ($urandom_range(0, 9) < 6) ? SIZE_BITS'($urandom_range(0, 65535))
                                                     : SIZE_BITS'($urandom_range(0, 4095));
                    load_part(BLK_W'($urandom_range(0, NUM_BLOCKS - 1)), amt);
                end else begin
                    case ($urandom_range(0, 19))
                        0:             amt = '0;
                        1, 2, 3:       amt = SIZE_BITS'($urandom_range(0, 65535));
                        4, 5, 6, 7, 8: amt = SIZE_BITS'($urandom_range(0, 4095));
                        default:       amt = SIZE_BITS'($urandom_range(0, 255));
                    endcase
                    request(amt);
                end
            end
        end
        no_gaps = 1'b0;

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* partition_fit_allocator.f */
rtl/pfa_pkg.sv
rtl/pfa_ctrl.sv
rtl/pfa_dp.sv
rtl/partition_fit_allocator.sv
verif/pfa_checker.sv
verif/tb_partition_fit_allocator.sv
